/* design/monthly_dose_ring_log_top_assert.svh */
// Assertion macros for the dose ring log checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MONTHLY_DOSE_RING_LOG_TOP_ASSERT_SVH
`define MONTHLY_DOSE_RING_LOG_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define MDRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define MDRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mdrl_pkg.sv */
// Shared types, constants and helpers for the monthly dose ring log.
// No dependencies; imported by the scan unit and the top level.
package mdrl_pkg;

  localparam int unsigned CELLS      = 16;
  localparam int unsigned IDX_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned TOT_W      = 32;
  localparam int unsigned SIDX_W     = 6;
  localparam int unsigned CELL_OUT_W = 4;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
  localparam logic [TOT_W-1:0] SAT_TOTAL = '1;

  typedef logic [IDX_W-1:0] cell_t;

  localparam cell_t LAST_CELL = IDX_W'(CELLS - 1);

  // Outcome of one walk over the stored keys
  typedef struct packed {
    logic  match;       // add: a cell holds the request key
    cell_t match_cell;  // add: first such cell
    logic  stop;        // walk reached its decision point
    logic  wipe;        // add: older key, clear the ring
    logic  fail;        // read: no data in the ring
    cell_t slot;        // add: cell to claim; read: oldest cell
  } scan_res_t;

  // Mask a cell index to the reported width
  function automatic logic [CELL_OUT_W-1:0] cell_to_out(cell_t c);
    logic [CELL_OUT_W+IDX_W-1:0] wide;
    wide = {{CELL_OUT_W{1'b0}}, c};
    return wide[CELL_OUT_W-1:0];
  endfunction

endpackage

/* design/mdrl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mdrl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mdrl_scan.sv */
// Walk unit: consumes one stored key per cycle in which step_i is set and works out the add or read decision.
// Depends on mdrl_pkg.
module mdrl_scan import mdrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic             read_mode_i,
  input  cell_t            cell_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] req_key_i,
  output scan_res_t        res_o
);

  scan_res_t        res_q, res_d;
  logic [KEY_W-1:0] prev_q, prev_d;

  // Update the decision with the key of the current cell
  always_comb begin
    res_d  = res_q;
    prev_d = prev_q;
    if (start_i) begin
      res_d = '0;
    end else if (step_i) begin
      // Remember the first cell holding the request key
      if (!read_mode_i && !res_q.match && (key_i == req_key_i)) begin
        res_d.match      = 1'b1;
        res_d.match_cell = cell_i;
      end
      // Follow rising keys until the newest cell is passed
      if (!res_q.stop) begin
        if (cell_i == '0) begin
          prev_d = key_i;
          if (read_mode_i) begin
            if ((key_i == EMPTY_KEY) || (key_i == '0)) begin
              res_d.stop = 1'b1;
              res_d.fail = 1'b1;
            end
          end else if (key_i == EMPTY_KEY) begin
            res_d.stop = 1'b1;
            res_d.slot = '0;
          end else if (key_i > req_key_i) begin
            res_d.stop = 1'b1;
            res_d.wipe = 1'b1;
          end
        end else if (key_i == EMPTY_KEY) begin
          res_d.stop = 1'b1;
          res_d.slot = read_mode_i ? cell_t'(0) : cell_i;
        end else if (!read_mode_i && (key_i > req_key_i)) begin
          res_d.stop = 1'b1;
          res_d.wipe = 1'b1;
        end else if (key_i > prev_q) begin
          prev_d = key_i;
        end else begin
          res_d.stop = 1'b1;
          res_d.slot = cell_i;
        end
      end
    end
  end

  // Hold the decision flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  // Hold the newest key seen so far
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

  assign res_o = res_q;

endmodule

/* design/monthly_dose_ring_log_top.sv */
// An add or read request walks all CELLS keys over the single read port, one per cycle from
// the key RAM, then touches the chosen cell: S_TOT raises a matched total, S_FETCH reads the
// target cell, and an add with no match claims a cell in S_RESOLVE. No new request is taken
// until the result has gone to the output register; a zero dose or an out-of-range read skips
// the walk. A stalled result holds the block for as long as it is stalled.
// Reset: control and per-cell valid bits clear at once; every cell reads as empty at once.
module monthly_dose_ring_log_top import mdrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [KEY_W-1:0]      month_key_i,
  input  logic [TOT_W-1:0]      dose_i,
  input  logic [SIDX_W-1:0]     sorted_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  ok_o,
  output logic [CELL_OUT_W-1:0] cell_used_o,
  output logic [KEY_W-1:0]      key_out_o,
  output logic [TOT_W-1:0]      total_out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LAST, S_RESOLVE, S_TOT, S_FETCH, S_OUT
  } state_e;

  state_e                  state_q, state_d;
  cell_t                   cnt_q, cnt_d;
  cell_t                   rd_addr_q, rd_addr_d;
  logic                    tag_vld_q, tag_vld_d;
  logic                    mode_q, mode_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic [TOT_W-1:0]        dose_q, dose_d;
  cell_t                   sidx_q, sidx_d;
  logic [CELLS-1:0]        cell_vld_q, cell_vld_d;
  logic                    res_ok_q, res_ok_d;
  cell_t                   res_cell_q, res_cell_d;
  logic [KEY_W-1:0]        res_key_q, res_key_d;
  logic [TOT_W-1:0]        res_tot_q, res_tot_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_ok_q, out_ok_d;
  logic [CELL_OUT_W-1:0]   out_cell_q, out_cell_d;
  logic [KEY_W-1:0]        out_key_q, out_key_d;
  logic [TOT_W-1:0]        out_tot_q, out_tot_d;

  logic                    in_acc;
  logic                    out_free;
  logic                    trivial;
  logic                    wr_key_en, wr_tot_en;
  cell_t                   wr_addr;
  logic [TOT_W-1:0]        wr_tot;
  logic [KEY_W-1:0]        key_rdata;
  logic [TOT_W-1:0]        tot_rdata_raw;
  logic [KEY_W-1:0]        key_rd;
  logic [TOT_W-1:0]        tot_rd;
  scan_res_t               scan_res;
  logic [IDX_W:0]          tgt_sum, tgt_wrap;
  cell_t                   target;
  cell_t                   claim;
  logic [TOT_W-1:0]        sum;
  logic [TOT_W-1:0]        new_tot;

  // Key and total stores, one cell per entry
  mdrl_ram #(.WIDTH(KEY_W), .DEPTH(CELLS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_key_en),
    .waddr_i (wr_addr),
    .wdata_i (key_q),
    .raddr_i (rd_addr_d),
    .rdata_o (key_rdata)
  );

  mdrl_ram #(.WIDTH(TOT_W), .DEPTH(CELLS)) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_tot_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_tot),
    .raddr_i (rd_addr_d),
    .rdata_o (tot_rdata_raw)
  );

  // Cells never written since reset or a wipe read as empty
  assign key_rd = cell_vld_q[rd_addr_q] ? key_rdata     : EMPTY_KEY;
  assign tot_rd = cell_vld_q[rd_addr_q] ? tot_rdata_raw : SAT_TOTAL;

  // Walk decision unit
  mdrl_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .step_i      (tag_vld_q),
    .read_mode_i (mode_q),
    .cell_i      (rd_addr_q),
    .key_i       (key_rd),
    .req_key_i   (key_q),
    .res_o       (scan_res)
  );

  // Handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Requests with nothing to look up
  assign trivial = mode_i ? ({1'b0, sorted_index_i} >= (SIDX_W + 1)'(CELLS))
                          : (dose_i == '0);

  // Chronological position to ring cell
  assign tgt_sum  = {1'b0, scan_res.slot} + {1'b0, sidx_q};
  assign tgt_wrap = (tgt_sum >= (IDX_W + 1)'(CELLS)) ? (tgt_sum - (IDX_W + 1)'(CELLS))
                                                      : tgt_sum;
  assign target   = tgt_wrap[IDX_W-1:0];

  // Cell claimed by an add that found no match
  assign claim = (scan_res.stop && !scan_res.wipe) ? scan_res.slot : cell_t'(0);

  // Saturating accumulate; an all-ones total stays put
  assign sum     = tot_rd + dose_q;
  assign new_tot = (tot_rd == SAT_TOTAL) ? SAT_TOTAL : ((sum > tot_rd) ? sum : SAT_TOTAL);

  // Sequence one request: walk, resolve, touch the cell, deliver
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_addr_d   = cnt_q;
    tag_vld_d   = 1'b0;
    mode_d      = mode_q;
    key_d       = key_q;
    dose_d      = dose_q;
    sidx_d      = sidx_q;
    cell_vld_d  = cell_vld_q;
    res_ok_d    = res_ok_q;
    res_cell_d  = res_cell_q;
    res_key_d   = res_key_q;
    res_tot_d   = res_tot_q;
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_cell_d  = out_cell_q;
    out_key_d   = out_key_q;
    out_tot_d   = out_tot_q;
    wr_key_en   = 1'b0;
    wr_tot_en   = 1'b0;
    wr_addr     = claim;
    wr_tot      = dose_q;

    // Drop a delivered result
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_d     = mode_i;
          key_d      = month_key_i;
          dose_d     = dose_i;
          sidx_d     = sorted_index_i[IDX_W-1:0];
          cnt_d      = '0;
          res_ok_d   = 1'b0;
          res_cell_d = '0;
          res_key_d  = '0;
          res_tot_d  = '0;
          state_d    = trivial ? S_OUT : S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one key read a cycle
        rd_addr_d = cnt_q;
        tag_vld_d = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = S_LAST;
        end else begin
          cnt_d = cnt_q + cell_t'(1);
        end
      end

      S_LAST: begin
        state_d = S_RESOLVE;
      end

      S_RESOLVE: begin
        if (mode_q) begin
          if (scan_res.fail) begin
            state_d = S_OUT;
          end else begin
            rd_addr_d = target;
            state_d   = S_FETCH;
          end
        end else if (scan_res.match) begin
          rd_addr_d = scan_res.match_cell;
          state_d   = S_TOT;
        end else begin
          // Claim a cell, wiping the ring first for an older key
          wr_key_en = 1'b1;
          wr_tot_en = 1'b1;
          wr_addr   = claim;
          wr_tot    = dose_q;
          if (scan_res.wipe) begin
            cell_vld_d = '0;
          end
          cell_vld_d[claim] = 1'b1;
          res_ok_d   = 1'b1;
          res_cell_d = claim;
          res_key_d  = key_q;
          res_tot_d  = dose_q;
          state_d    = S_OUT;
        end
      end

      S_TOT: begin
        // Write back the raised total unless already saturated
        wr_addr    = rd_addr_q;
        wr_tot     = new_tot;
        wr_tot_en  = (tot_rd != SAT_TOTAL);
        res_ok_d   = 1'b1;
        res_cell_d = rd_addr_q;
        res_key_d  = key_q;
        res_tot_d  = new_tot;
        state_d    = S_OUT;
      end

      S_FETCH: begin
        if (key_rd != EMPTY_KEY) begin
          res_ok_d   = 1'b1;
          res_cell_d = rd_addr_q;
          res_key_d  = key_rd;
          res_tot_d  = tot_rd;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_cell_d  = cell_to_out(res_cell_q);
          out_key_d   = res_key_q;
          out_tot_d   = res_tot_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, request and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_addr_q   <= '0;
      tag_vld_q   <= 1'b0;
      mode_q      <= 1'b0;
      key_q       <= '0;
      dose_q      <= '0;
      sidx_q      <= '0;
      cell_vld_q  <= '0;
      res_ok_q    <= 1'b0;
      res_cell_q  <= '0;
      res_key_q   <= '0;
      res_tot_q   <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_cell_q  <= '0;
      out_key_q   <= '0;
      out_tot_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_addr_q   <= rd_addr_d;
      tag_vld_q   <= tag_vld_d;
      mode_q      <= mode_d;
      key_q       <= key_d;
      dose_q      <= dose_d;
      sidx_q      <= sidx_d;
      cell_vld_q  <= cell_vld_d;
      res_ok_q    <= res_ok_d;
      res_cell_q  <= res_cell_d;
      res_key_q   <= res_key_d;
      res_tot_q   <= res_tot_d;
      out_valid_q <= out_valid_d;
      out_ok_q    <= out_ok_d;
      out_cell_q  <= out_cell_d;
      out_key_q   <= out_key_d;
      out_tot_q   <= out_tot_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;
  assign cell_used_o = out_cell_q;
  assign key_out_o   = out_key_q;
  assign total_out_o = out_tot_q;

endmodule

/* design/mdrl_checker.sv */
// Port-level checker for the dose ring log, bound to the top level.
// Depends on monthly_dose_ring_log_top_assert.svh.
`include "monthly_dose_ring_log_top_assert.svh"

module mdrl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        ok_o,
  input logic [3:0]  cell_used_o,
  input logic [31:0] key_out_o,
  input logic [31:0] total_out_o
);

  // Hold a stalled result
  `MDRL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(ok_o) && $stable(cell_used_o) && $stable(key_out_o) && $stable(total_out_o), "stalled result changed")

  // A failed request carries zero fields
  `MDRL_ASSERT_NOW(a_fail_zero, out_valid_o && !ok_o, (cell_used_o == '0) && (key_out_o == '0) && (total_out_o == '0), "failed result has non-zero fields")

  // Only one request in flight
  `MDRL_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

  // A new result only comes from a request in progress
  `MDRL_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o), "result appeared while idle")

endmodule

bind monthly_dose_ring_log_top mdrl_checker u_mdrl_checker (.*);
